### rtl/fca_pkg.sv
// fca_pkg: shared types, codes and constants of the fat16 cluster chain allocator
// used by the controller, the datapath and the top level
// no dependencies
package fca_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	// field widths
	localparam int ENTRY_W    = 16;
	localparam int LEN_W      = 32;
	localparam int CC_W       = 13;
	localparam int MEDIA_W    = 8;
	localparam int SHIFT_W    = 4;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIA_TYPE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT = 2'd2;

	// configuration reset values
	localparam logic [CC_W-1:0]    CC_RESET    = 13'd4096;
	localparam logic [MEDIA_W-1:0] MEDIA_RESET = 8'd248;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd11;

	// request codes
	localparam logic [1:0] FN_FORMAT = 2'd0;
	localparam logic [1:0] FN_ALLOC  = 2'd1;
	localparam logic [1:0] FN_FREE   = 2'd2;
	localparam logic [1:0] FN_READ   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_LONG    = 2'd3;

	// entry constants
	localparam logic [7:0]         ENTRY0_HI  = 8'hFF;
	localparam logic [ENTRY_W-1:0] END_MARK   = 16'hFFFF;
	localparam logic [ENTRY_W-1:0] FREE_ENTRY = 16'h0000;
	localparam int                 FIRST_DATA = 2;

	typedef struct packed {
		logic [1:0]       func;
		logic [LEN_W-1:0] byte_length;
		logic [15:0]      cluster;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        first_cluster;
		logic [ENTRY_W-1:0] entry_value;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       fmt_init;
		logic       fmt_step;
		logic       rd_issue;
		logic       em_issue;
		logic       em_latch;
		logic       scan_init;
		logic       cnt_step;
		logic       link_step;
		logic       tail_write;
		logic       fr_issue;
		logic       fr_eval;
		logic       fin;
		logic [1:0] fin_status;
		logic       fin_head;
		logic       fin_value;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       need_zero;
		logic       read_range_bad;
		logic       free_range_bad;
		logic       fmt_last;
		logic       scan_done;
		logic       space_short;
		logic       rem_zero;
		logic       steps_over;
		logic       next_is_end;
		logic       next_bad;
	} sts_t;

endpackage

### rtl/fca_ctrl.sv
// fca_ctrl: request sequencer of the fat16 cluster chain allocator
// drives cmd_t towards fca_dp and reacts to its sts_t; uses fca_pkg
module fca_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output fca_pkg::cmd_t cmd,
	input  fca_pkg::sts_t sts
);
	import fca_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_FMT  = 4'd2;
	localparam logic [3:0] S_RDW  = 4'd3;
	localparam logic [3:0] S_EMW  = 4'd4;
	localparam logic [3:0] S_CNT  = 4'd5;
	localparam logic [3:0] S_CHK  = 4'd6;
	localparam logic [3:0] S_LINK = 4'd7;
	localparam logic [3:0] S_TAIL = 4'd8;
	localparam logic [3:0] S_FI   = 4'd9;
	localparam logic [3:0] S_FE   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.func)
					FN_FORMAT: begin
						cmd.fmt_init = 1'b1;
						state_d      = S_FMT;
					end
					FN_READ: begin
						if (sts.read_range_bad) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_RANGE;
							state_d        = S_IDLE;
						end else begin
							cmd.rd_issue = 1'b1;
							state_d      = S_RDW;
						end
					end
					FN_ALLOC: begin
						if (sts.need_zero) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_OK;
							cmd.fin_head   = 1'b1;
							state_d        = S_IDLE;
						end else begin
							cmd.em_issue = 1'b1;
							state_d      = S_EMW;
						end
					end
					FN_FREE: begin
						if (sts.free_range_bad) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_RANGE;
							state_d        = S_IDLE;
						end else begin
							cmd.em_issue = 1'b1;
							state_d      = S_EMW;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FMT: begin
				cmd.fmt_step = 1'b1;
				if (sts.fmt_last) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_OK;
					state_d        = S_IDLE;
				end
			end
			S_RDW: begin
				cmd.fin        = 1'b1;
				cmd.fin_status = ST_OK;
				cmd.fin_value  = 1'b1;
				state_d        = S_IDLE;
			end
			S_EMW: begin
				cmd.em_latch  = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = (sts.func == FN_ALLOC) ? S_CNT : S_FI;
			end
			S_CNT: begin
				cmd.cnt_step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.space_short) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_NOSPACE;
					state_d        = S_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_LINK;
				end
			end
			S_LINK: begin
				cmd.link_step = 1'b1;
				if (sts.rem_zero) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				cmd.tail_write = 1'b1;
				cmd.fin        = 1'b1;
				cmd.fin_status = ST_OK;
				cmd.fin_head   = 1'b1;
				state_d        = S_IDLE;
			end
			S_FI: begin
				if (sts.steps_over) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_LONG;
					state_d        = S_IDLE;
				end else begin
					cmd.fr_issue = 1'b1;
					state_d      = S_FE;
				end
			end
			S_FE: begin
				cmd.fr_eval = 1'b1;
				if (sts.next_is_end) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_OK;
					state_d        = S_IDLE;
				end else if (sts.next_bad) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_RANGE;
					state_d        = S_IDLE;
				end else begin
					state_d = S_FI;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/fca_dp.sv
// fca_dp: datapath of the fat16 cluster chain allocator
// holds the configuration registers, the allocation table memory and the result register
// driven by cmd_t from fca_ctrl; uses fca_pkg
module fca_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [fca_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fca_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  fca_pkg::req_t                         req,
	input  fca_pkg::cmd_t                         cmd,
	output fca_pkg::sts_t                         sts,
	output logic                                  result_valid,
	output fca_pkg::res_t                         result
);
	import fca_pkg::*;

	// configuration
	logic [CC_W-1:0]    cluster_count_q;
	logic [MEDIA_W-1:0] media_type_q;
	logic [SHIFT_W-1:0] cluster_shift_q;

	// request context
	logic [1:0]         func_q;
	logic [15:0]        cl_q;
	logic [LEN_W-1:0]   need_q;
	logic [CNT_W-1:0]   n_q;
	logic [ENTRY_W-1:0] endmark_q;

	// format, scan and walk state
	logic [IDX_W-1:0]   w_q;
	logic [CNT_W-1:0]   s_q;
	logic               rv_s1;
	logic [IDX_W-1:0]   ri_s1;
	logic [CNT_W-1:0]   freecnt_q;
	logic [CNT_W-1:0]   rem_q;
	logic [IDX_W-1:0]   prev_q;
	logic               prev_vld_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   c_q;
	logic [CNT_W-1:0]   steps_q;

	// table memory
	logic [ENTRY_W-1:0] tbl_q [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;
	logic               re;
	logic [IDX_W-1:0]   raddr;

	logic               res_valid_q;
	res_t               res_q;

	logic [CNT_W-1:0]   n_w;
	logic [LEN_W-1:0]   frac_mask;
	logic [LEN_W-1:0]   need_w;
	logic               iss;
	logic               link_hit;

	// configuration writes, ready is tied high at the top level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= CC_RESET;
			media_type_q    <= MEDIA_RESET;
			cluster_shift_q <= SHIFT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CLUSTER_COUNT: cluster_count_q <= cfg_data[CC_W-1:0];
				CFG_MEDIA_TYPE:    media_type_q    <= cfg_data[MEDIA_W-1:0];
				CFG_CLUSTER_SHIFT: cluster_shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective entry count, clamped to the table and to the reserved pair
	always_comb begin
		if (32'(cluster_count_q) > TABLE_DEPTH) begin
			n_w = CNT_W'(TABLE_DEPTH);
		end else if (32'(cluster_count_q) < FIRST_DATA) begin
			n_w = CNT_W'(FIRST_DATA);
		end else begin
			n_w = CNT_W'(cluster_count_q);
		end
	end

	// clusters needed: length rounded up to whole clusters
	assign frac_mask = (LEN_W'(1) << cluster_shift_q) - LEN_W'(1);
	assign need_w    = (req.byte_length >> cluster_shift_q)
		+ LEN_W'(|(req.byte_length & frac_mask));

	// scan pipeline controls
	assign iss      = (cmd.cnt_step || cmd.link_step) && (s_q < n_q);
	assign link_hit = cmd.link_step && rv_s1 && (rdata_q == FREE_ENTRY) && (rem_q != '0);

	// request context and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= req.func;
			cl_q    <= req.cluster;
			need_q  <= need_w;
			n_q     <= n_w;
			head_q  <= '0;
			c_q     <= req.cluster[IDX_W-1:0];
			steps_q <= '0;
		end
		if (cmd.em_latch) begin
			endmark_q <= rdata_q;
		end
		if (cmd.fmt_init) begin
			w_q <= '0;
		end else if (cmd.fmt_step) begin
			w_q <= w_q + IDX_W'(1);
		end
		if (cmd.scan_init) begin
			s_q        <= CNT_W'(FIRST_DATA);
			freecnt_q  <= '0;
			rem_q      <= need_q[CNT_W-1:0];
			prev_vld_q <= 1'b0;
		end else begin
			if (iss) begin
				s_q <= s_q + CNT_W'(1);
			end
			if (cmd.cnt_step && rv_s1 && (rdata_q == FREE_ENTRY)) begin
				freecnt_q <= freecnt_q + CNT_W'(1);
			end
			if (link_hit) begin
				rem_q      <= rem_q - CNT_W'(1);
				prev_q     <= ri_s1;
				prev_vld_q <= 1'b1;
				if (!prev_vld_q) begin
					head_q <= ri_s1;
				end
			end
		end
		ri_s1 <= s_q[IDX_W-1:0];
		if (cmd.fr_eval) begin
			c_q     <= rdata_q[IDX_W-1:0];
			steps_q <= steps_q + CNT_W'(1);
		end
	end

	// read data of the scan pipeline is valid in the cycle after issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= iss && !cmd.scan_init;
		end
	end

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = w_q;
		wdata = FREE_ENTRY;
		if (cmd.fmt_step) begin
			we    = 1'b1;
			waddr = w_q;
			if (w_q == IDX_W'(0)) begin
				wdata = {ENTRY0_HI, media_type_q};
			end else if (w_q == IDX_W'(1)) begin
				wdata = END_MARK;
			end else begin
				wdata = FREE_ENTRY;
			end
		end else if (link_hit && prev_vld_q) begin
			we    = 1'b1;
			waddr = prev_q;
			wdata = ENTRY_W'(ri_s1);
		end else if (cmd.tail_write) begin
			we    = 1'b1;
			waddr = prev_q;
			wdata = endmark_q;
		end else if (cmd.fr_eval) begin
			we    = 1'b1;
			waddr = c_q;
			wdata = FREE_ENTRY;
		end
	end

	// read port select
	always_comb begin
		re    = 1'b0;
		raddr = s_q[IDX_W-1:0];
		if (cmd.rd_issue) begin
			re    = 1'b1;
			raddr = cl_q[IDX_W-1:0];
		end else if (cmd.em_issue) begin
			re    = 1'b1;
			raddr = IDX_W'(1);
		end else if (iss) begin
			re    = 1'b1;
			raddr = s_q[IDX_W-1:0];
		end else if (cmd.fr_issue) begin
			re    = 1'b1;
			raddr = c_q;
		end
	end

	// allocation table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			tbl_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= tbl_q[raddr];
		end
	end

	// status towards the controller
	always_comb begin
		sts.func           = func_q;
		sts.need_zero      = (need_q == '0);
		sts.read_range_bad = (cl_q >= 16'(n_q));
		sts.free_range_bad = (cl_q < 16'(FIRST_DATA)) || (cl_q >= 16'(n_q));
		sts.fmt_last       = (CNT_W'(w_q) == (n_q - CNT_W'(1)));
		sts.scan_done      = !(s_q < n_q) && !rv_s1;
		sts.space_short    = (LEN_W'(freecnt_q) < need_q);
		sts.rem_zero       = (rem_q == '0);
		sts.steps_over     = (steps_q >= (n_q - CNT_W'(FIRST_DATA)));
		sts.next_is_end    = (rdata_q == endmark_q);
		sts.next_bad       = (rdata_q < ENTRY_W'(FIRST_DATA)) || (rdata_q >= ENTRY_W'(n_q));
	end

	// result register, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			res_q.status        <= cmd.fin_status;
			res_q.first_cluster <= cmd.fin_head ? 16'(head_q) : 16'd0;
			res_q.entry_value   <= cmd.fin_value ? rdata_q : FREE_ENTRY;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### rtl/fat16_cluster_chain_allocator_core.sv
// fat16_cluster_chain_allocator_core: top level, one request at a time, result strobed one cycle.
// Read returns one entry; format writes every entry below the effective entry count n; allocate
// counts free entries, fails when too few, else links the first free ones and ends the chain with
// the end mark; free clears the chain up to its end mark, failing on a bad link or too long a chain.
// Zero length and range errors of the request end at dispatch; the table is walked entry by entry.
// Reset: control state cleared and configuration registers set to their defaults asynchronously;
// table contents undefined until a format. The receiver cannot stall: the strobe is shown once.
module fat16_cluster_chain_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  fca_pkg::req_t                  req,
	output logic                           result_valid,
	output fca_pkg::res_t                  result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fca_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fca_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// configuration is taken in any cycle
	assign cfg_ready = 1'b1;

	// sequencer
	fca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// table, configuration and result
	fca_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req          (req),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### rtl/fca_checker.sv
// fca_checker: port-level checks of the fat16 cluster chain allocator
// bound to fat16_cluster_chain_allocator_core; does not use fca_pkg
module fca_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid
);

	// an accepted request keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// the result strobe comes as the block leaves busy
	a_fell_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy dropped without a result transfer");

	// no result while a request is still at work
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result transfer while busy");

	// every result follows a busy cycle
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result transfer without a request");

endmodule

bind fat16_cluster_chain_allocator_core fca_checker u_fca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid)
);
